// ===== sv/ufe_pkg.sv =====
package ufe_pkg;

  // Fixed field widths of the request and result items
  localparam int IDX_W       = 10;
  localparam int COUNT_OUT_W = 11;

  // Element indices never reach past this, whatever the element count
  localparam int MAX_DEPTH   = 1 << IDX_W;

  typedef enum logic {
    OP_UNION = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_WALK_A = 7'b0000100,
    ST_WALK_B = 7'b0001000,
    ST_SIZE_A = 7'b0010000,
    ST_SIZE_B = 7'b0100000,
    ST_RESP   = 7'b1000000
  } state_e;

endpackage

// ===== sv/ufe_ram.sv =====
module ufe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/weighted_union_find_engine_unit.sv =====
// Weighted quick-union disjoint-set engine (no path compression). Each request
// carries an operation (union or connected query) and two element indices; the
// block answers with one result: whether the pair already shared a root, the
// first element's root after the request, the component count, and an error
// flag for an index at or above ELEMENT_COUNT (then nothing changes). After
// reset the block runs a clearing pass over the parent and size memories, one
// entry per cycle over min(ELEMENT_COUNT, 1024) entries (1024 at the default),
// with in_ready_o low. A request walks the first element up to its root, then
// the second; a union of unconnected elements then reads both root sizes and
// links the trees. Weighting keeps each link depth at most log2(1024) = 10. An
// out-of-range request skips the walks. The root walk follows one link per
// cycle, as the parent memory has a single read port. One request is in flight
// at a time; the result sits in an output register, so the next request is
// taken while an earlier result still waits for out_ready_i.
module weighted_union_find_engine_unit #(
  parameter int ELEMENT_COUNT = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                operation_i,
  input  logic [ufe_pkg::IDX_W-1:0]           first_element_i,
  input  logic [ufe_pkg::IDX_W-1:0]           second_element_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                were_connected_o,
  output logic [ufe_pkg::IDX_W-1:0]           first_root_o,
  output logic [ufe_pkg::COUNT_OUT_W-1:0]     component_count_o,
  output logic                                index_error_o
);

  import ufe_pkg::*;

  // Only indices below the field range can ever be addressed
  localparam int DEPTH = (ELEMENT_COUNT > MAX_DEPTH) ? MAX_DEPTH : ELEMENT_COUNT;
  localparam int AW    = $clog2(DEPTH);
  // A tree never holds more than DEPTH reachable elements
  localparam int SW    = $clog2(DEPTH + 1);
  localparam int CW    = $clog2(ELEMENT_COUNT + 1);

  state_e         state_q, state_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic [AW-1:0]  node_q, node_d;
  logic [AW-1:0]  b_q, b_d;
  logic [AW-1:0]  root_a_q, root_a_d;
  logic [AW-1:0]  root_b_q, root_b_d;
  logic [SW-1:0]  size_a_q, size_a_d;
  op_e            op_q, op_d;
  logic           joined_q, joined_d;
  logic           err_q, err_d;
  logic [CW-1:0]  count_q, count_d;

  logic                   out_valid_q, out_valid_d;
  logic                   out_joined_q, out_joined_d;
  logic [IDX_W-1:0]       out_root_q, out_root_d;
  logic [COUNT_OUT_W-1:0] out_count_q, out_count_d;
  logic                   out_err_q, out_err_d;

  logic           in_xfer;
  logic           bad_index;
  logic           found;
  logic           a_smaller;
  logic [SW-1:0]  size_sum;
  logic           out_load;

  logic           par_we;
  logic [AW-1:0]  par_waddr, par_wdata, par_raddr, par_rdata;
  logic           size_we;
  logic [AW-1:0]  size_waddr, size_raddr;
  logic [SW-1:0]  size_wdata, size_rdata;

  ufe_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (par_we),
    .waddr_i (par_waddr),
    .wdata_i (par_wdata),
    .raddr_i (par_raddr),
    .rdata_o (par_rdata)
  );

  ufe_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (size_we),
    .waddr_i (size_waddr),
    .wdata_i (size_wdata),
    .raddr_i (size_raddr),
    .rdata_o (size_rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign bad_index  = (32'(first_element_i) >= ELEMENT_COUNT) ||
                      (32'(second_element_i) >= ELEMENT_COUNT);

  // Shared compare: the walked node is a root when it is its own parent
  assign found      = (par_rdata == node_q);

  // Weighting: on equal sizes the second root goes under the first
  assign a_smaller  = (size_a_q < size_rdata);
  assign size_sum   = size_a_q + size_rdata;

  // Read address for the next cycle follows the walk
  assign par_raddr  = node_d;
  assign size_raddr = (state_q == ST_SIZE_A) ? root_b_q : root_a_q;

  // Memory writes: clearing pass, or the single link of a union
  always_comb begin
    par_we     = 1'b0;
    par_waddr  = a_smaller ? root_a_q : root_b_q;
    par_wdata  = a_smaller ? root_b_q : root_a_q;
    size_we    = 1'b0;
    size_waddr = a_smaller ? root_b_q : root_a_q;
    size_wdata = size_sum;
    if (state_q == ST_CLEAR) begin
      par_we     = 1'b1;
      par_waddr  = clr_q;
      par_wdata  = clr_q;
      size_we    = 1'b1;
      size_waddr = clr_q;
      size_wdata = SW'(1);
    end else if (state_q == ST_SIZE_B) begin
      par_we  = 1'b1;
      size_we = 1'b1;
    end
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    node_d   = node_q;
    b_d      = b_q;
    root_a_d = root_a_q;
    root_b_d = root_b_q;
    size_a_d = size_a_q;
    op_d     = op_q;
    joined_d = joined_q;
    err_d    = err_q;
    count_d  = count_q;
    out_load = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        node_d = first_element_i[AW-1:0];
        if (in_xfer) begin
          op_d     = op_e'(operation_i);
          b_d      = second_element_i[AW-1:0];
          err_d    = bad_index;
          joined_d = 1'b0;
          state_d  = bad_index ? ST_RESP : ST_WALK_A;
        end
      end
      ST_WALK_A: begin
        if (found) begin
          root_a_d = node_q;
          node_d   = b_q;
          state_d  = ST_WALK_B;
        end else begin
          node_d = par_rdata;
        end
      end
      ST_WALK_B: begin
        if (found) begin
          root_b_d = node_q;
          joined_d = (root_a_q == node_q);
          // Queries and already joined pairs leave the tables alone
          if ((root_a_q == node_q) || (op_q == OP_QUERY)) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_SIZE_A;
          end
        end else begin
          node_d = par_rdata;
        end
      end
      ST_SIZE_A: begin
        size_a_d = size_rdata;
        state_d  = ST_SIZE_B;
      end
      ST_SIZE_B: begin
        if (a_smaller) begin
          root_a_d = root_b_q;
        end
        if (count_q > CW'(1)) begin
          count_d = count_q - CW'(1);
        end
        state_d = ST_RESP;
      end
      ST_RESP: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d  = out_valid_q;
    out_joined_d = out_joined_q;
    out_root_d   = out_root_q;
    out_count_d  = out_count_q;
    out_err_d    = out_err_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_joined_d = err_q ? 1'b0 : joined_q;
      out_root_d   = err_q ? '0 : IDX_W'(root_a_q);
      out_count_d  = COUNT_OUT_W'(count_q);
      out_err_d    = err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      count_q     <= CW'(ELEMENT_COUNT);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q       <= node_d;
    b_q          <= b_d;
    root_a_q     <= root_a_d;
    root_b_q     <= root_b_d;
    size_a_q     <= size_a_d;
    op_q         <= op_d;
    joined_q     <= joined_d;
    err_q        <= err_d;
    out_joined_q <= out_joined_d;
    out_root_q   <= out_root_d;
    out_count_q  <= out_count_d;
    out_err_q    <= out_err_d;
  end

  assign out_valid_o       = out_valid_q;
  assign were_connected_o  = out_joined_q;
  assign first_root_o      = out_root_q;
  assign component_count_o = out_count_q;
  assign index_error_o     = out_err_q;

`ifndef SYNTHESIS
  // One request at a time: an accepted transfer closes the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a request is in flight");

  // A pending result must not be overwritten by the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP) && out_valid_q && !out_ready_i |=> (state_q == ST_RESP))
    else $error("result loaded over an untaken result");

  // The component count never drops to zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0)
    else $error("component count reached zero");
`endif

endmodule
